// File: design/assert_macros.svh
// assertion helpers for the divider
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/srtd_pkg.sv
package srtd_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned CNT_W  = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX,
        ST_DONE
    } state_t;

endpackage

// File: design/srtd_step.sv
// one step unit of two chained subtractors: two restoring quotient bits per cycle
module srtd_step (
    input  logic [64:0] rem_in,
    input  logic [63:0] num_in,
    input  logic [63:0] den,
    output logic [64:0] rem_out,
    output logic [63:0] num_out,
    output logic [1:0]  bits
);
    logic [64:0] r1;
    logic [64:0] d1;
    logic [64:0] r1s;
    logic [64:0] r2;
    logic [64:0] d2;

    always_comb
    begin
        r1      = {rem_in[63:0], num_in[63]};
        d1      = r1 - {1'b0, den};
        bits[1] = !d1[64];
        r1s     = d1[64] ? r1 : d1;
        r2      = {r1s[63:0], num_in[62]};
        d2      = r2 - {1'b0, den};
        bits[0] = !d2[64];
        rem_out = d2[64] ? r2 : d2;
        num_out = {num_in[61:0], 2'b00};
    end
endmodule

// File: design/srt_radix8_integer_divider.sv
// iterative divider: one operand transfer in, one quotient transfer out
// sequence: after the input transfer, 32 two-bit steps and one fix step (sign,
// zero divisor) precede output valid; one item at a time
// a new item is taken only in idle, after the previous quotient is accepted
// reset: rst_n asynchronous active low clears the sequencer; no result pending
module srt_radix8_integer_divider (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: dividend[63:0], divisor[127:64], half_width[128], is_signed[129], zeros
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: quotient[63:0]
    output logic [63:0]  m_axis_tdata
);
    srtd_pkg::state_t state_reg, state_next;
    logic [srtd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic        neg_reg, neg_next;

    logic [63:0] a, b, ma, mb;
    logic        na, nb;
    logic [64:0] step_rem;
    logic [63:0] step_num;
    logic [1:0]  step_bits;

    // operand masking and magnitudes
    always_comb
    begin
        a  = s_axis_tdata[63:0];
        b  = s_axis_tdata[127:64];
        if (s_axis_tdata[128])
        begin
            a[31:0] = '0;
            b[31:0] = '0;
        end
        na = s_axis_tdata[129] & a[63];
        nb = s_axis_tdata[129] & b[63];
        ma = na ? (64'd0 - a) : a;
        mb = nb ? (64'd0 - b) : b;
    end

    // quotient bits shift into num as dividend bits leave
    srtd_step u_step (
        .rem_in  (rem_reg),
        .num_in  (num_reg),
        .den     (den_reg),
        .rem_out (step_rem),
        .num_out (step_num),
        .bits    (step_bits)
    );

    assign s_axis_tready = (state_reg == srtd_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == srtd_pkg::ST_DONE);
    assign m_axis_tdata  = num_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srtd_pkg::ST_IDLE: if (s_axis_tvalid) state_next = srtd_pkg::ST_RUN;
            srtd_pkg::ST_RUN:  if (cnt_reg == '1) state_next = srtd_pkg::ST_FIX;
            srtd_pkg::ST_FIX:  state_next = srtd_pkg::ST_DONE;
            srtd_pkg::ST_DONE: if (m_axis_tready) state_next = srtd_pkg::ST_IDLE;
            default:           state_next = srtd_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        num_next = num_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        unique case (state_reg)
            srtd_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                rem_next = '0;
                num_next = ma;
                den_next = mb;
                neg_next = na ^ nb;
            end
            srtd_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                rem_next = step_rem;
                num_next = {step_num[63:2], step_bits};
            end
            srtd_pkg::ST_FIX:
            begin
                // zero divisor yields all ones from the loop; force zero
                if (den_reg == '0)
                    num_next = '0;
                else if (neg_reg)
                    num_next = 64'd0 - num_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srtd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_excl, clk, rst_n, 1'b1, !(s_axis_tready && m_axis_tvalid))
    `ASSERT_NEXT(a_start, clk, rst_n, s_axis_tvalid && s_axis_tready,
        state_reg == srtd_pkg::ST_RUN && cnt_reg == '0)
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule
